FILE: hdl/jdpd_pkg.sv
`timescale 1ns / 1ps

package jdpd_pkg;

  localparam logic [7:0]  OP_RAW   = 8'd0;
  localparam logic [7:0]  OP_EPOCH = 8'd1;
  localparam logic [7:0]  OP_BIN   = 8'd2;
  localparam logic [7:0]  OP_BCD   = 8'd3;

  localparam logic [22:0] REFORM_DAY      = 23'd2299161;
  localparam logic [31:0] EPOCH_DAY       = 32'd2451911;
  localparam logic [9:0]  TICK_MULT_RESET = 10'd675;

  // Reciprocal constants: floor(2^S / divisor), one correction step after each
  localparam logic [8:0]  ALPHA_RECIP = 9'd293;        // 3652425, S = 30
  localparam logic [11:0] HOUR_RECIP  = 12'd2330;      // 3600, S = 23
  localparam logic [21:0] DOW_RECIP   = 22'd2396745;   // 7, S = 24
  localparam logic [14:0] CENT_RECIP  = 15'd29397;     // 36525, S = 30
  localparam logic [6:0]  MIN_RECIP   = 7'd68;         // 60, S = 12
  localparam logic [19:0] MONTH_RECIP = 20'd540000;    // 10000 * 54, 306001, S = 24
  localparam logic [27:0] DAYS_RECIP  = 28'd256428838; // 306001 * 838, 10000, S = 23
  localparam logic [9:0]  YEAR_RECIP  = 10'd655;       // 100, S = 16

  typedef struct packed {
    logic [7:0]         op;
    logic [22:0]        jd;
    logic [22:0]        secs;
    logic               ge;
    logic [29:0]        x1;
    logic [7:0]         alpha;
    logic [11:0]        hour;
    logic [11:0]        rem;
    logic [20:0]        dq;
    logic [2:0]         dow;
    logic [23:0]        b;
    logic [29:0]        x2;
    logic [14:0]        c;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         w;
    logic [4:0]         e;
    logic [9:0]         t;
    logic [3:0]         month;
    logic signed [15:0] year;
    logic [9:0]         day;
    logic               neg;
    logic [15:0]        ym;
    logic [11:0]        cmag;
    logic [6:0]         ymag;
  } pipe_t;

  typedef struct packed {
    logic [31:0] date_word;
    logic [31:0] time_word;
  } result_t;

  // (v / 10) * 16 + v % 10 for a 12-bit value
  function automatic logic [15:0] bcd12(input logic [11:0] v);
    logic [20:0] p;
    logic [8:0]  q;
    logic [11:0] r;
    p = 21'(v) * 21'd409;
    q = p[20:12];
    r = v - 12'(q) * 12'd10;
    if (r >= 12'd10) begin
      q = q + 9'd1;
      r = r - 12'd10;
    end
    return 16'({q, 4'b0000}) + 16'(r);
  endfunction

endpackage

FILE: hdl/jdpd_if.sv
`timescale 1ns / 1ps

interface jdpd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  operation;
  logic [22:0] day_number;
  logic [30:0] tick_count;
  modport source (output valid, operation, day_number, tick_count, input ready);
  modport sink (input valid, operation, day_number, tick_count, output ready);
endinterface

interface jdpd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] date_word;
  logic [31:0] time_word;
  modport source (output valid, date_word, time_word, input ready);
  modport sink (input valid, date_word, time_word, output ready);
endinterface

interface jdpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] tick_multiplier;
  modport source (output valid, tick_multiplier, input ready);
  modport sink (input valid, tick_multiplier, output ready);
endinterface

FILE: hdl/jdpd_fmt.sv
`timescale 1ns / 1ps

module jdpd_fmt (
  input  jdpd_pkg::pipe_t   st,
  output jdpd_pkg::result_t res
);
  import jdpd_pkg::*;

  logic [31:0] y32;
  logic [31:0] bc, by, bm, bd, bh, bn, bs;
  logic [31:0] bin_date, bin_time, bcd_date, bcd_time;

  always_comb begin
    y32 = {{16{st.year[15]}}, st.year};
    bin_date = ((((y32 << 4) + 32'(st.month)) << 8) + 32'(st.day)) << 4;
    bin_date = bin_date + 32'(st.dow);
    bin_time = (((32'(st.hour) << 8) + 32'(st.minute)) << 8) + 32'(st.second);

    // negative years carry the sign into both century and year bytes
    bc = 32'(bcd12(st.cmag));
    by = 32'(bcd12(12'(st.ymag)));
    if (st.neg) begin
      bc = -bc;
      by = -by;
    end
    bm = 32'(bcd12(12'(st.month)));
    bd = 32'(bcd12(12'(st.day)));
    bh = 32'(bcd12(st.hour));
    bn = 32'(bcd12(12'(st.minute)));
    bs = 32'(bcd12(12'(st.second)));
    bcd_date = (((((bc << 8) | by) << 8) | bm) << 8) | bd;
    bcd_time = (((bh << 8) | bn) << 8) | bs;

    unique case (st.op)
      OP_RAW: begin
        res.date_word = 32'(st.jd);
        res.time_word = 32'(st.secs);
      end
      OP_BIN: begin
        res.date_word = bin_date;
        res.time_word = bin_time;
      end
      OP_BCD: begin
        res.date_word = bcd_date;
        res.time_word = bcd_time;
      end
      default: begin
        res.date_word = 32'(st.jd) - EPOCH_DAY;
        res.time_word = 32'(st.secs);
      end
    endcase
  end

endmodule

FILE: hdl/julian_day_to_packed_datetime_core.sv
`timescale 1ns / 1ps

// Converts a Julian day number and a timer tick count into a raw, epoch-relative,
// packed binary or packed BCD date and time word pair. Every division by a constant
// ahead of the output formatter is a reciprocal multiply followed one stage later by a
// single correction, which cuts the work into a 14-stage pipeline: one word enters per
// cycle while nothing stalls. Each stage holds its word until the next stage frees up,
// so a stalled output leaves the earlier stages filling bubbles.
// The tick multiplier register resets to 675 and is written through the cfg channel,
// which is always ready; write it only while the pipeline is empty.
module julian_day_to_packed_datetime_core (
  input logic      clk,
  input logic      rst_n,
  jdpd_in_if.sink  in_if,
  jdpd_out_if.source out_if,
  jdpd_cfg_if.sink cfg_if
);
  import jdpd_pkg::*;

  localparam int NST = 13;

  logic [9:0]  mult_r;
  pipe_t       st_r   [1:NST];
  pipe_t       st_nxt [1:NST];
  logic [NST+1:1] v_r;
  logic [NST+2:1] rdy;
  result_t     res_nxt;
  result_t     res_r;

  // intermediate products
  logic [40:0] p1;
  logic [30:0] x1f;
  logic [38:0] p2a;
  logic [34:0] p2h;
  logic [23:0] jd1_2, jd1_3;
  logic [45:0] p2d;
  logic [29:0] p3a;
  logic [23:0] p3h, r3h, r3d;
  logic [23:0] a4;
  logic [30:0] x2f;
  logic [44:0] p5c;
  logic [18:0] p5m;
  logic [30:0] p6c;
  logic [11:0] p6m, r6m;
  logic [23:0] d7;
  logic [29:0] p8;
  logic [23:0] x9;
  logic [24:0] p9;
  logic [32:0] p10;
  logic [23:0] x11, p11;
  logic [9:0]  t11;
  logic [15:0] ym12;
  logic [25:0] p12;
  logic [15:0] p13, r13;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= TICK_MULT_RESET;
    end else if (cfg_if.valid) begin
      mult_r <= cfg_if.tick_multiplier;
    end
  end

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    rdy[NST+2] = out_if.ready;
    for (int k = NST + 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_if.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_if.valid;
      for (int k = 2; k <= NST + 1; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NST; k++) begin
      if (rdy[k]) st_r[k] <= st_nxt[k];
    end
    if (rdy[NST+1]) res_r <= res_nxt;
  end

  // stage 1: seconds, alpha numerator
  always_comb begin
    st_nxt[1] = '0;
    p1 = 41'(in_if.tick_count) * 41'(mult_r);
    x1f = 31'(in_if.day_number) * 31'd100 - 31'd186721625;
    st_nxt[1].op = in_if.operation;
    st_nxt[1].jd = in_if.day_number;
    st_nxt[1].secs = p1[31:9];
    st_nxt[1].ge = (in_if.day_number >= REFORM_DAY);
    st_nxt[1].x1 = st_nxt[1].ge ? x1f[29:0] : 30'd0;
  end

  // stage 2: quotient estimates
  always_comb begin
    st_nxt[2] = st_r[1];
    p2a = 39'(st_r[1].x1) * 39'(ALPHA_RECIP);
    st_nxt[2].alpha = p2a[37:30];
    p2h = 35'(st_r[1].secs) * 35'(HOUR_RECIP);
    st_nxt[2].hour = p2h[34:23];
    jd1_2 = 24'(st_r[1].jd) + 24'd1;
    p2d = 46'(jd1_2) * 46'(DOW_RECIP);
    st_nxt[2].dq = p2d[44:24];
  end

  // stage 3: correct alpha, hour and weekday
  always_comb begin
    st_nxt[3] = st_r[2];
    p3a = 30'(st_r[2].alpha) * 30'd3652425;
    if ({1'b0, st_r[2].x1} >= 31'(p3a) + 31'd3652425) begin
      st_nxt[3].alpha = st_r[2].alpha + 8'd1;
    end
    p3h = 24'(st_r[2].hour) * 24'd3600;
    r3h = 24'(st_r[2].secs) - p3h;
    if (r3h >= 24'd3600) begin
      st_nxt[3].hour = st_r[2].hour + 12'd1;
      st_nxt[3].rem = 12'(r3h - 24'd3600);
    end else begin
      st_nxt[3].rem = r3h[11:0];
    end
    jd1_3 = 24'(st_r[2].jd) + 24'd1;
    r3d = jd1_3 - 24'(st_r[2].dq) * 24'd7;
    st_nxt[3].dow = (r3d >= 24'd7) ? 3'(r3d - 24'd7) : r3d[2:0];
  end

  // stage 4: b and the year numerator
  always_comb begin
    st_nxt[4] = st_r[3];
    a4 = st_r[3].ge ? 24'(st_r[3].jd) + 24'd1 + 24'(st_r[3].alpha)
                      - 24'(st_r[3].alpha >> 2)
                    : 24'(st_r[3].jd);
    st_nxt[4].b = a4 + 24'd1524;
    x2f = 31'(st_nxt[4].b) * 31'd100 - 31'd12210;
    st_nxt[4].x2 = x2f[29:0];
  end

  // stage 5: estimate c and minutes
  always_comb begin
    st_nxt[5] = st_r[4];
    p5c = 45'(st_r[4].x2) * 45'(CENT_RECIP);
    st_nxt[5].c = p5c[44:30];
    p5m = 19'(st_r[4].rem) * 19'(MIN_RECIP);
    st_nxt[5].minute = p5m[17:12];
  end

  // stage 6: correct c, minutes, seconds
  always_comb begin
    st_nxt[6] = st_r[5];
    p6c = 31'(st_r[5].c) * 31'd36525;
    if ({1'b0, st_r[5].x2} >= p6c + 31'd36525) begin
      st_nxt[6].c = st_r[5].c + 15'd1;
    end
    p6m = 12'(st_r[5].minute) * 12'd60;
    r6m = st_r[5].rem - p6m;
    if (r6m >= 12'd60) begin
      st_nxt[6].minute = st_r[5].minute + 6'd1;
      st_nxt[6].second = 6'(r6m - 12'd60);
    end else begin
      st_nxt[6].second = r6m[5:0];
    end
  end

  // stage 7: day within the shifted year; 36525c/100 is 365c + c/4
  always_comb begin
    st_nxt[7] = st_r[6];
    d7 = 24'(st_r[6].c) * 24'd365 + 24'(st_r[6].c >> 2);
    st_nxt[7].w = 10'(st_r[6].b - d7);
  end

  // stage 8: estimate e
  always_comb begin
    st_nxt[8] = st_r[7];
    p8 = 30'(st_r[7].w) * 30'(MONTH_RECIP);
    st_nxt[8].e = p8[28:24];
  end

  // stage 9: correct e
  always_comb begin
    st_nxt[9] = st_r[8];
    x9 = 24'(st_r[8].w) * 24'd10000;
    p9 = 25'(st_r[8].e) * 25'd306001;
    if ({1'b0, x9} >= p9 + 25'd306001) begin
      st_nxt[9].e = st_r[8].e + 5'd1;
    end
  end

  // stage 10: month, year, estimate of the days before the month
  always_comb begin
    st_nxt[10] = st_r[9];
    p10 = 33'(st_r[9].e) * 33'(DAYS_RECIP);
    st_nxt[10].t = p10[32:23];
    st_nxt[10].month = (st_r[9].e <= 5'd13) ? 4'(st_r[9].e - 5'd1)
                                            : 4'(st_r[9].e - 5'd13);
    st_nxt[10].year = (st_nxt[10].month > 4'd2)
                    ? $signed({1'b0, st_r[9].c}) - 16'sd4716
                    : $signed({1'b0, st_r[9].c}) - 16'sd4715;
  end

  // stage 11: correct and subtract to get the day of month
  always_comb begin
    st_nxt[11] = st_r[10];
    x11 = 24'(st_r[10].e) * 24'd306001;
    p11 = 24'(st_r[10].t) * 24'd10000;
    t11 = (x11 >= p11 + 24'd10000) ? st_r[10].t + 10'd1 : st_r[10].t;
    st_nxt[11].t = t11;
    st_nxt[11].day = st_r[10].w - t11;
  end

  // stage 12: sign and magnitude of the year, estimate century
  always_comb begin
    st_nxt[12] = st_r[11];
    st_nxt[12].neg = st_r[11].year[15];
    ym12 = st_r[11].year[15] ? 16'(-st_r[11].year) : 16'(st_r[11].year);
    st_nxt[12].ym = ym12;
    p12 = 26'(ym12) * 26'(YEAR_RECIP);
    st_nxt[12].cmag = 12'(p12[25:16]);
  end

  // stage 13: correct century, year within century
  always_comb begin
    st_nxt[13] = st_r[12];
    p13 = 16'(st_r[12].cmag) * 16'd100;
    r13 = st_r[12].ym - p13;
    if (r13 >= 16'd100) begin
      st_nxt[13].cmag = st_r[12].cmag + 12'd1;
      st_nxt[13].ymag = 7'(r13 - 16'd100);
    end else begin
      st_nxt[13].ymag = r13[6:0];
    end
  end

  jdpd_fmt u_fmt (
    .st  (st_r[NST]),
    .res (res_nxt)
  );

  assign out_if.valid     = v_r[NST+1];
  assign out_if.date_word = res_r.date_word;
  assign out_if.time_word = res_r.time_word;

endmodule

FILE: hdl/jdpd_chk.sv
`timescale 1ns / 1ps

module jdpd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] date_word,
  input logic [31:0] time_word
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(date_word) && $stable(time_word))
    else $error("stalled output word changed");

  // a draining output frees every stage
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind julian_day_to_packed_datetime_core jdpd_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .date_word (out_if.date_word),
  .time_word (out_if.time_word)
);
